// ===== hw/rtl/cel_pkg.sv =====
`timescale 1ns / 1ps

package cel_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int FIELD_BITS            = 16;
    localparam int KIND_BITS             = 5;
    localparam int MAX_TOKENS            = 3;
    localparam int QUEUE_DEPTH           = 4;
    localparam int QUEUE_PTR_BITS        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS        = $clog2(QUEUE_DEPTH + 1);
    localparam int TDATA_BITS            = 56;

    localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_DOT    = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_SLASH  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_CARET  = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_INT    = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_SIN    = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_COS    = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_COSEC  = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_TAN    = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_ERROR  = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_EOF    = 5'd20;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
        logic                  last;
    } token_t;

    // Tokens released by one input byte, in emission order, with how many are valid.
    typedef struct packed {
        logic [1:0]                 count;
        token_t [MAX_TOKENS-1:0]    tok;
    } token_burst_t;

endpackage

// ===== hw/rtl/cel_scanner.sv =====
`timescale 1ns / 1ps

module cel_scanner #(
    parameter int POSITION_BITS = cel_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            char_code,
    input  logic                  end_of_text,
    output cel_pkg::token_burst_t burst
);

    localparam int PB = POSITION_BITS;
    localparam int CW = (PB > cel_pkg::FIELD_BITS) ? PB : cel_pkg::FIELD_BITS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_DOT,
        MODE_FRAC,
        MODE_SLASH,
        MODE_COMMENT
    } mode_t;

    mode_t                           mode_reg, mode_next;
    logic [PB-1:0]                   begin_reg, begin_next;
    logic [PB-1:0]                   pos_reg, pos_next;
    logic [cel_pkg::FIELD_BITS-1:0]  line_reg, line_next;
    logic [39:0]                     lead_reg, lead_next;
    logic [2:0]                      cnt_reg, cnt_next;

    cel_pkg::token_t f0, f1, st_tok, s_tok;
    logic            fv0, fv1, st_v, sv;
    mode_t           st_mode;
    logic            st_newline, st_ident, st_mark;
    logic            do_start, flush_en;
    logic [1:0]      n_tok;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [cel_pkg::FIELD_BITS-1:0] clamp16(input logic [PB-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext > CW'(16'hFFFF))
            return 16'hFFFF;
        return ext[cel_pkg::FIELD_BITS-1:0];
    endfunction

    function automatic logic [PB-1:0] span(input logic [PB-1:0] from, input logic [PB-1:0] to);
        return (to > from) ? (to - from) : '0;
    endfunction

    function automatic cel_pkg::token_t make_tok(input logic [cel_pkg::KIND_BITS-1:0] kind,
                                                 input logic [PB-1:0] start,
                                                 input logic [PB-1:0] len,
                                                 input logic [cel_pkg::FIELD_BITS-1:0] line);
        cel_pkg::token_t t;
        t.kind   = kind;
        t.start  = clamp16(start);
        t.length = clamp16(len);
        t.line   = line;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic [cel_pkg::KIND_BITS-1:0] ident_kind(input logic [39:0] lead,
                                                                 input logic [2:0] cnt);
        if (cnt == 3'd3 && lead[23:0] == {"t", "n", "i"})
            return cel_pkg::KIND_INT;
        if (cnt == 3'd3 && lead[23:0] == {"n", "i", "s"})
            return cel_pkg::KIND_SIN;
        if (cnt == 3'd3 && lead[23:0] == {"s", "o", "c"})
            return cel_pkg::KIND_COS;
        if (cnt == 3'd5 && lead == {"c", "e", "s", "o", "c"})
            return cel_pkg::KIND_COSEC;
        if (cnt == 3'd3 && lead[23:0] == {"n", "a", "t"})
            return cel_pkg::KIND_TAN;
        return cel_pkg::KIND_IDENT;
    endfunction

    // Whatever token the current mode holds, as if flushed at the current offset.
    always_comb
    begin
        f0  = make_tok(cel_pkg::KIND_NUMBER, begin_reg, span(begin_reg, pos_reg), line_reg);
        f1  = make_tok(cel_pkg::KIND_DOT, pos_reg - PB'(1), PB'(1), line_reg);
        fv0 = 1'b0;
        fv1 = 1'b0;
        unique case (mode_reg)
            MODE_IDENT:
            begin
                f0 = make_tok(ident_kind(lead_reg, cnt_reg), begin_reg,
                              span(begin_reg, pos_reg), line_reg);
                fv0 = 1'b1;
            end
            MODE_INT, MODE_FRAC:
            begin
                fv0 = 1'b1;
            end
            MODE_DOT:
            begin
                // The held dot belongs after the number, one byte before here.
                f0 = make_tok(cel_pkg::KIND_NUMBER, begin_reg,
                              span(begin_reg, pos_reg - PB'(1)), line_reg);
                fv0 = 1'b1;
                fv1 = 1'b1;
            end
            MODE_SLASH:
            begin
                f0  = make_tok(cel_pkg::KIND_SLASH, begin_reg, PB'(1), line_reg);
                fv0 = 1'b1;
            end
            default:
            begin
                fv0 = 1'b0;
            end
        endcase
    end

    // Outcome of starting afresh on the incoming byte.
    always_comb
    begin
        st_mode    = MODE_IDLE;
        st_newline = 1'b0;
        st_ident   = 1'b0;
        st_mark    = 1'b0;
        st_v       = 1'b0;
        st_tok     = make_tok(cel_pkg::KIND_ERROR, pos_reg, PB'(1), line_reg);
        if (char_code == " " || char_code == "\r" || char_code == "\t")
        begin
            st_mode = MODE_IDLE;
        end
        else if (char_code == "\n")
        begin
            st_newline = 1'b1;
        end
        else if (is_alpha(char_code))
        begin
            st_mode  = MODE_IDENT;
            st_ident = 1'b1;
            st_mark  = 1'b1;
        end
        else if (is_digit(char_code))
        begin
            st_mode = MODE_INT;
            st_mark = 1'b1;
        end
        else if (char_code == "/")
        begin
            st_mode = MODE_SLASH;
            st_mark = 1'b1;
        end
        else
        begin
            st_v = 1'b1;
            unique case (char_code)
                "(":     st_tok.kind = cel_pkg::KIND_LPAREN;
                ")":     st_tok.kind = cel_pkg::KIND_RPAREN;
                "{":     st_tok.kind = cel_pkg::KIND_LBRACE;
                "}":     st_tok.kind = cel_pkg::KIND_RBRACE;
                ";":     st_tok.kind = cel_pkg::KIND_SEMI;
                ",":     st_tok.kind = cel_pkg::KIND_COMMA;
                ".":     st_tok.kind = cel_pkg::KIND_DOT;
                "-":     st_tok.kind = cel_pkg::KIND_MINUS;
                "+":     st_tok.kind = cel_pkg::KIND_PLUS;
                "*":     st_tok.kind = cel_pkg::KIND_STAR;
                "^":     st_tok.kind = cel_pkg::KIND_CARET;
                default: st_tok.kind = cel_pkg::KIND_ERROR;
            endcase
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        line_next  = line_reg;
        lead_next  = lead_reg;
        cnt_next   = cnt_reg;
        do_start   = 1'b0;
        flush_en   = 1'b0;
        sv         = 1'b0;
        s_tok      = st_tok;

        if (take)
        begin
            if (end_of_text)
            begin
                flush_en   = 1'b1;
                sv         = 1'b1;
                s_tok      = make_tok(cel_pkg::KIND_EOF, pos_reg, '0, line_reg);
                mode_next  = MODE_IDLE;
                begin_next = '0;
                pos_next   = '0;
                line_next  = 16'd1;
                lead_next  = '0;
                cnt_next   = '0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_alpha(char_code) || is_digit(char_code))
                        begin
                            for (int i = 0; i < 5; i++)
                                if (cnt_reg == 3'(i))
                                    lead_next[8*i +: 8] = char_code;
                            if (cnt_reg < 3'd6)
                                cnt_next = cnt_reg + 3'd1;
                        end
                        else
                            do_start = 1'b1;
                    end
                    MODE_INT:
                    begin
                        if (char_code == ".")
                            mode_next = MODE_DOT;
                        else if (!is_digit(char_code))
                            do_start = 1'b1;
                    end
                    MODE_DOT:
                    begin
                        if (is_digit(char_code))
                            mode_next = MODE_FRAC;
                        else
                            do_start = 1'b1;
                    end
                    MODE_FRAC:
                    begin
                        if (!is_digit(char_code))
                            do_start = 1'b1;
                    end
                    MODE_SLASH:
                    begin
                        if (char_code == "/")
                            mode_next = MODE_COMMENT;
                        else
                            do_start = 1'b1;
                    end
                    MODE_COMMENT:
                    begin
                        if (char_code == "\n")
                            do_start = 1'b1;
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                if (do_start)
                begin
                    flush_en  = 1'b1;
                    sv        = st_v;
                    mode_next = st_mode;
                    if (st_mark)
                        begin_next = pos_reg;
                    if (st_ident)
                    begin
                        lead_next = {32'd0, char_code};
                        cnt_next  = 3'd1;
                    end
                    if (st_newline && line_reg != 16'hFFFF)
                        line_next = line_reg + 16'd1;
                end

                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + PB'(1);
            end
        end
    end

    // Pack flushed tokens first, then the token of the new byte.
    always_comb
    begin
        logic ev0, ev1;
        ev0   = flush_en && fv0;
        ev1   = flush_en && fv1;
        n_tok = 2'(ev0) + 2'(ev1) + 2'(sv);
        burst.count  = n_tok;
        burst.tok[0] = ev0 ? f0 : s_tok;
        burst.tok[1] = ev1 ? f1 : s_tok;
        burst.tok[2] = s_tok;
        for (int i = 0; i < cel_pkg::MAX_TOKENS; i++)
            burst.tok[i].last = (n_tok == 2'(i + 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= 16'd1;
            lead_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            lead_reg  <= lead_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/cel_token_queue.sv =====
`timescale 1ns / 1ps

module cel_token_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cel_pkg::token_burst_t burst,
    output logic                  room,
    output logic                  valid,
    input  logic                  ready,
    output cel_pkg::token_t       head
);

    localparam int PW = cel_pkg::QUEUE_PTR_BITS;
    localparam int CW = cel_pkg::QUEUE_CNT_BITS;

    cel_pkg::token_t entry_reg [cel_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pop;
    logic [1:0]      n_push;

    // A request is taken only when a full burst of tokens is sure to fit.
    assign room   = cnt_reg <= CW'(cel_pkg::QUEUE_DEPTH - cel_pkg::MAX_TOKENS);
    assign valid  = cnt_reg != '0;
    assign head   = entry_reg[rd_reg];
    assign pop    = valid && ready;
    assign n_push = push ? burst.count : 2'd0;

    always_comb
    begin
        wr_next  = wr_reg + PW'(n_push);
        rd_next  = pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + CW'(n_push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cel_pkg::MAX_TOKENS; i++)
            if (2'(i) < n_push)
                entry_reg[wr_reg + PW'(i)] <= burst.tok[i];
    end

endmodule

// ===== hw/rtl/calculator_expression_lexer_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_*       in         tdata[7:0] source byte, tlast end of text
// m_*       out        tdata token fields, tlast final token of a source byte
//
// One source byte is taken per cycle while s_tready is high; its tokens (none
// to three) are written to a four-entry token queue at the accepting edge and
// leave it one per cycle while m_tready is high, behind any tokens queued before.
// A byte is taken while the queue holds at most one token, so a byte that
// releases two or three tokens stalls the input until no more than one token
// is left queued.
// Reset empties the queue and returns the scanner to line 1, offset 0.
// End of text flushes the pending token, emits eof and rewinds the scanner.

module calculator_expression_lexer_core #(
    parameter int POSITION_BITS = cel_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] char_code
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [4:0] token_kind, [20:5] token_start, [36:21] token_length,
    // [52:37] token_line, [55:53] zero
    output logic [cel_pkg::TDATA_BITS-1:0] m_tdata,
    output logic                           m_tlast
);

    cel_pkg::token_burst_t burst;
    cel_pkg::token_t       head;
    logic                  take;

    assign take = s_tvalid && s_tready;

    cel_scanner #(
        .POSITION_BITS (POSITION_BITS)
    ) u_scanner (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .char_code   (s_tdata),
        .end_of_text (s_tlast),
        .burst       (burst)
    );

    cel_token_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .burst (burst),
        .room  (s_tready),
        .valid (m_tvalid),
        .ready (m_tready),
        .head  (head)
    );

    assign m_tdata = {3'b000, head.line, head.length, head.start, head.kind};
    assign m_tlast = head.last;

endmodule
